### hw/rtl/arlm_pkg.sv
// shared widths and constants for the audio rms level meter
// no dependencies; every other file of the block depends on this package
`timescale 1ns / 1ps

package arlm_pkg;

   // mid value after rescaling to 16 bits, and its square
   localparam int MID_W = 16;
   localparam int SQ_W = 2 * MID_W;

   // block accumulator of squared mid values
   localparam int SUM_W = 41;

   // digit-by-digit square root, two radicand bits per step
   localparam int ROOT_W = (SUM_W + 1) / 2;
   localparam int RAD_W = 2 * ROOT_W;
   localparam int REM_W = ROOT_W + 2;

   // level, rms and smoothing weight
   localparam int LEVEL_W = 16;
   localparam int DECAY_W = 16;
   localparam int PROD_W = LEVEL_W + 2 + DECAY_W;

   localparam logic [DECAY_W-1:0] DECAY_RESET = 16'd55706;
   localparam logic [LEVEL_W-1:0] LEVEL_ONE = 16'h8000;

endpackage

### hw/rtl/arlm_if.sv
// request and response channel interfaces of the audio rms level meter
// depends on arlm_pkg for the response field widths
`timescale 1ns / 1ps

interface arlm_req_if #(
   parameter int SAMPLE_BITS = 16
);
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] left_sample;
   logic signed [SAMPLE_BITS-1:0] right_sample;
   logic                          block_end;

   modport source (output valid, left_sample, right_sample, block_end, input ready);
   modport sink   (input valid, left_sample, right_sample, block_end, output ready);
endinterface

interface arlm_rsp_if;
   logic                                valid;
   logic                                ready;
   logic [arlm_pkg::LEVEL_W-1:0]        smoothed_level;
   logic [arlm_pkg::LEVEL_W-1:0]        block_rms;

   modport source (output valid, smoothed_level, block_rms, input ready);
   modport sink   (input valid, smoothed_level, block_rms, output ready);
endinterface

### hw/rtl/audio_rms_level_meter.sv
// a frame word holds the request side until the 16-step squarer is done; a block_end word
//   shows its result once the squarer, 41-step divider, 21-step square root, 16-step blend
//   and output register load have run in turn
// throughput: frames past the block limit that do not close it are taken one per cycle;
//   any other word holds off new words until it is through; a waiting result does too
// reset: synchronous, active high; clears sum, frame count and level, loads default decay
`timescale 1ns / 1ps

module audio_rms_level_meter #(
   parameter int MAX_FRAMES = 1024,
   parameter int SAMPLE_BITS = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   arlm_req_if.sink                     req_bus,
   arlm_rsp_if.source                   rsp_bus,
   input  logic                         csr_wr_en,
   input  logic [arlm_pkg::DECAY_W-1:0] csr_wr_data
);
   import arlm_pkg::*;

   localparam int CNT_W = $clog2(MAX_FRAMES + 1);
   localparam logic [CNT_W-1:0] FRAMES_FULL = CNT_W'(MAX_FRAMES);
   localparam int PAD_W = SUM_W + 1 - SQ_W;

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_SQ    = 6'b000010,
      ST_DIV   = 6'b000100,
      ST_SQRT  = 6'b001000,
      ST_BLEND = 6'b010000,
      ST_OUT   = 6'b100000
   } state_type;

   state_type          state_ff, state_in;
   logic               go_ff, go_in;            // one-cycle start for the unit just entered
   logic               end_ff, end_in;          // current word closes its block
   logic [MID_W-1:0]   mag_ff, mag_in;          // magnitude of the rescaled mid value
   logic [SUM_W-1:0]   sum_ff, sum_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [LEVEL_W-1:0] level_ff, level_in;
   logic [LEVEL_W-1:0] rms_ff, rms_in;
   logic [DECAY_W-1:0] decay_ff, decay_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [LEVEL_W-1:0] rsp_level_ff, rsp_level_in;
   logic [LEVEL_W-1:0] rsp_rms_ff, rsp_rms_in;

   // mid value and its magnitude
   logic [SAMPLE_BITS:0]   pair_sum;
   logic [SAMPLE_BITS-1:0] half;
   logic [MID_W-1:0]       mid16;
   logic [MID_W-1:0]       mag_calc;

   // accumulator update
   logic [SUM_W:0]     sum_wide;
   logic [SUM_W-1:0]   sum_sat;
   logic               block_full;

   // units
   logic               sq_start, sq_done;
   logic [SQ_W-1:0]    sq_square;
   logic               div_start, div_done;
   logic [SUM_W-1:0]   div_mean;
   logic               sqrt_start, sqrt_done;
   logic [ROOT_W-1:0]  sqrt_root;
   logic               blend_start, blend_done;
   logic [LEVEL_W-1:0] blend_level;
   logic               accept;

   // floor((l + r) / 2) is the top bits of the sign-extended sum
   assign pair_sum = {req_bus.left_sample[SAMPLE_BITS-1], req_bus.left_sample}
                   + {req_bus.right_sample[SAMPLE_BITS-1], req_bus.right_sample};
   assign half = pair_sum[SAMPLE_BITS:1];

   // rescale to 16 bits: floor shift for wide samples, zero fill for narrow ones
   generate
      if (SAMPLE_BITS >= MID_W) begin : g_wide
         assign mid16 = half[SAMPLE_BITS-1 -: MID_W];
      end else begin : g_narrow
         assign mid16 = {half, {(MID_W - SAMPLE_BITS){1'b0}}};
      end
   endgenerate

   // most negative value maps to 0x8000, which is its magnitude read unsigned
   assign mag_calc = mid16[MID_W-1] ? (~mid16 + MID_W'(1)) : mid16;

   assign accept = req_bus.valid && req_bus.ready;
   assign req_bus.ready = (state_ff == ST_IDLE);

   // frames past the block limit leave sum and count untouched
   assign block_full = (count_ff >= FRAMES_FULL);

   // saturating accumulate of the finished square
   assign sum_wide = {1'b0, sum_ff} + {{PAD_W{1'b0}}, sq_square};
   assign sum_sat = sum_wide[SUM_W] ? {SUM_W{1'b1}} : sum_wide[SUM_W-1:0];

   assign sq_start = go_ff && (state_ff == ST_SQ);
   assign div_start = go_ff && (state_ff == ST_DIV);
   assign sqrt_start = go_ff && (state_ff == ST_SQRT);
   assign blend_start = go_ff && (state_ff == ST_BLEND);

   always_comb begin
      state_in = state_ff;
      go_in = 1'b0;
      end_in = end_ff;
      mag_in = mag_ff;
      sum_in = sum_ff;
      count_in = count_ff;
      level_in = level_ff;
      rms_in = rms_ff;
      rsp_level_in = rsp_level_ff;
      rsp_rms_in = rsp_rms_ff;
      // a shown result drops once taken
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      decay_in = csr_wr_en ? csr_wr_data : decay_ff;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               end_in = req_bus.block_end;
               mag_in = mag_calc;
               if (!block_full) begin
                  state_in = ST_SQ;
                  go_in = 1'b1;
               end else if (req_bus.block_end) begin
                  // full block: the closing frame only triggers the average
                  state_in = ST_DIV;
                  go_in = 1'b1;
               end
            end
         end
         ST_SQ: begin
            if (sq_done) begin
               sum_in = sum_sat;
               count_in = count_ff + CNT_W'(1);
               if (end_ff) begin
                  state_in = ST_DIV;
                  go_in = 1'b1;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_DIV: begin
            // count is at least one here, the closing frame guarantees it
            if (div_done) begin
               state_in = ST_SQRT;
               go_in = 1'b1;
            end
         end
         ST_SQRT: begin
            if (sqrt_done) begin
               rms_in = (sqrt_root > ROOT_W'(LEVEL_ONE)) ? LEVEL_ONE
                                                        : sqrt_root[LEVEL_W-1:0];
               state_in = ST_BLEND;
               go_in = 1'b1;
            end
         end
         ST_BLEND: begin
            if (blend_done) begin
               level_in = blend_level;
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            // wait for the output register to free up, then start a fresh block
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_valid_in = 1'b1;
               rsp_level_in = level_ff;
               rsp_rms_in = rms_ff;
               sum_in = '0;
               count_in = '0;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         go_ff <= 1'b0;
         sum_ff <= '0;
         count_ff <= '0;
         level_ff <= '0;
         decay_ff <= DECAY_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         go_ff <= go_in;
         sum_ff <= sum_in;
         count_ff <= count_in;
         level_ff <= level_in;
         decay_ff <= decay_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      end_ff <= end_in;
      mag_ff <= mag_in;
      rms_ff <= rms_in;
      rsp_level_ff <= rsp_level_in;
      rsp_rms_ff <= rsp_rms_in;
   end

   assign rsp_bus.valid = rsp_valid_ff;
   assign rsp_bus.smoothed_level = rsp_level_ff;
   assign rsp_bus.block_rms = rsp_rms_ff;

   // squared mid value, one bit of the magnitude per cycle
   arlm_square u_square (
      .clock  (clock),
      .reset  (reset),
      .start  (sq_start),
      .mag    (mag_ff),
      .done   (sq_done),
      .square (sq_square)
   );

   // block mean: sum over frame count
   arlm_div #(
      .CNT_W (CNT_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (sum_ff),
      .divisor  (count_ff),
      .done     (div_done),
      .quotient (div_mean)
   );

   // block rms from the mean
   arlm_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sqrt_start),
      .radicand (div_mean),
      .done     (sqrt_done),
      .root     (sqrt_root)
   );

   // smoothed level update
   arlm_blend u_blend (
      .clock     (clock),
      .reset     (reset),
      .start     (blend_start),
      .level     (level_ff),
      .rms       (rms_ff),
      .decay     (decay_ff),
      .done      (blend_done),
      .new_level (blend_level)
   );

endmodule

### hw/rtl/arlm_square.sv
// bit-serial squarer: one multiplier bit per cycle, shift-add into a 17-bit adder
// depends on arlm_pkg
`timescale 1ns / 1ps

module arlm_square (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [arlm_pkg::MID_W-1:0]  mag,
   output logic                        done,
   output logic [arlm_pkg::SQ_W-1:0]   square
);
   import arlm_pkg::*;

   localparam int CNT_W = $clog2(MID_W);
   localparam logic [CNT_W-1:0] LAST = CNT_W'(MID_W - 1);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [MID_W-1:0] mcand_ff, mcand_in;
   logic [MID_W-1:0] hi_ff, hi_in;
   logic [MID_W-1:0] lo_ff, lo_in;
   logic [MID_W:0]   psum;

   always_comb begin
      psum = {1'b0, hi_ff} + (lo_ff[0] ? {1'b0, mcand_ff} : {(MID_W + 1){1'b0}});
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in = cnt_ff;
      mcand_in = mcand_ff;
      hi_in = hi_ff;
      lo_in = lo_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in = '0;
         mcand_in = mag;
         hi_in = '0;
         lo_in = mag;
      end else if (busy_ff) begin
         // low product bits shift in as multiplier bits shift out
         hi_in = psum[MID_W:1];
         lo_in = {psum[0], lo_ff[MID_W-1:1]};
         cnt_in = cnt_ff + CNT_W'(1);
         if (cnt_ff == LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      mcand_ff <= mcand_in;
      hi_ff <= hi_in;
      lo_ff <= lo_in;
   end

   assign done = done_ff;
   assign square = {hi_ff, lo_ff};

endmodule

### hw/rtl/arlm_div.sv
// restoring divider: one quotient bit per cycle, remainder as narrow as the divisor
// depends on arlm_pkg
`timescale 1ns / 1ps

module arlm_div #(
   parameter int CNT_W = 11
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [arlm_pkg::SUM_W-1:0] dividend,
   input  logic [CNT_W-1:0]           divisor,
   output logic                       done,
   output logic [arlm_pkg::SUM_W-1:0] quotient
);
   import arlm_pkg::*;

   localparam int STEP_W = $clog2(SUM_W);
   localparam logic [STEP_W-1:0] LAST = STEP_W'(SUM_W - 1);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [STEP_W-1:0] cnt_ff, cnt_in;
   logic [SUM_W-1:0]  dq_ff, dq_in;
   logic [CNT_W-1:0]  rem_ff, rem_in;
   logic [CNT_W-1:0]  dvs_ff, dvs_in;
   logic [CNT_W:0]    trial;
   logic [CNT_W:0]    diff;
   logic              ge;

   always_comb begin
      trial = {rem_ff, dq_ff[SUM_W-1]};
      diff = trial - {1'b0, dvs_ff};
      ge = (trial >= {1'b0, dvs_ff});
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in = cnt_ff;
      dq_in = dq_ff;
      rem_in = rem_ff;
      dvs_in = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in = '0;
         dq_in = dividend;
         rem_in = '0;
         dvs_in = divisor;
      end else if (busy_ff) begin
         // dividend bits leave at the top, quotient bits enter at the bottom
         rem_in = ge ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
         dq_in = {dq_ff[SUM_W-2:0], ge};
         cnt_in = cnt_ff + STEP_W'(1);
         if (cnt_ff == LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      dq_ff <= dq_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign done = done_ff;
   assign quotient = dq_ff;

endmodule

### hw/rtl/arlm_sqrt.sv
// digit-by-digit integer square root: one root bit per cycle, floor result
// depends on arlm_pkg
`timescale 1ns / 1ps

module arlm_sqrt (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [arlm_pkg::SUM_W-1:0]  radicand,
   output logic                        done,
   output logic [arlm_pkg::ROOT_W-1:0] root
);
   import arlm_pkg::*;

   localparam int STEP_W = $clog2(ROOT_W);
   localparam logic [STEP_W-1:0] LAST = STEP_W'(ROOT_W - 1);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [STEP_W-1:0] cnt_ff, cnt_in;
   logic [RAD_W-1:0]  rad_ff, rad_in;
   logic [REM_W-1:0]  rem_ff, rem_in;
   logic [ROOT_W-1:0] root_ff, root_in;
   logic [REM_W-1:0]  shifted;
   logic [REM_W-1:0]  trial;
   logic              ge;

   always_comb begin
      // remainder never exceeds twice the root, so its top two bits are clear here
      shifted = {rem_ff[REM_W-3:0], rad_ff[RAD_W-1 -: 2]};
      trial = {root_ff, 2'b01};
      ge = (shifted >= trial);
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in = cnt_ff;
      rad_in = rad_ff;
      rem_in = rem_ff;
      root_in = root_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in = '0;
         rad_in = {{(RAD_W - SUM_W){1'b0}}, radicand};
         rem_in = '0;
         root_in = '0;
      end else if (busy_ff) begin
         rem_in = ge ? (shifted - trial) : shifted;
         root_in = {root_ff[ROOT_W-2:0], ge};
         rad_in = {rad_ff[RAD_W-3:0], 2'b00};
         cnt_in = cnt_ff + STEP_W'(1);
         if (cnt_ff == LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rad_ff <= rad_in;
      rem_ff <= rem_in;
      root_ff <= root_in;
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule

### hw/rtl/arlm_blend.sv
// exponential smoothing: rms*2^16 + (level - rms)*decay, bit-serial over the weight
// depends on arlm_pkg
`timescale 1ns / 1ps

module arlm_blend (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [arlm_pkg::LEVEL_W-1:0] level,
   input  logic [arlm_pkg::LEVEL_W-1:0] rms,
   input  logic [arlm_pkg::DECAY_W-1:0] decay,
   output logic                         done,
   output logic [arlm_pkg::LEVEL_W-1:0] new_level
);
   import arlm_pkg::*;

   localparam int DIFF_W = LEVEL_W + 1;
   localparam int HI_W = LEVEL_W + 2;
   localparam int STEP_W = $clog2(DECAY_W);
   localparam logic [STEP_W-1:0] LAST = STEP_W'(DECAY_W - 1);
   localparam logic [PROD_W-1:0] ROUND_HALF = PROD_W'(1) << (DECAY_W - 1);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [STEP_W-1:0] cnt_ff, cnt_in;
   logic [DIFF_W-1:0] diff_ff, diff_in;
   logic [LEVEL_W-1:0] rms_ff, rms_in;
   logic [HI_W-1:0]   hi_ff, hi_in;
   logic [DECAY_W-1:0] lo_ff, lo_in;
   logic [HI_W-1:0]   psum;
   logic [PROD_W-1:0] total;
   logic [HI_W-1:0]   scaled;

   always_comb begin
      psum = hi_ff + (lo_ff[0] ? {diff_ff[DIFF_W-1], diff_ff} : {HI_W{1'b0}});
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in = cnt_ff;
      diff_in = diff_ff;
      rms_in = rms_ff;
      hi_in = hi_ff;
      lo_in = lo_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in = '0;
         diff_in = {1'b0, level} - {1'b0, rms};
         rms_in = rms;
         hi_in = '0;
         lo_in = decay;
      end else if (busy_ff) begin
         // signed partial product shifts right arithmetically
         hi_in = {psum[HI_W-1], psum[HI_W-1:1]};
         lo_in = {psum[0], lo_ff[DECAY_W-1:1]};
         cnt_in = cnt_ff + STEP_W'(1);
         if (cnt_ff == LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // final sum is never negative, so plain modular adds are exact
   always_comb begin
      total = {2'b00, rms_ff, {DECAY_W{1'b0}}} + {hi_ff, lo_ff} + ROUND_HALF;
      scaled = total[PROD_W-1:DECAY_W];
      new_level = (scaled > {2'b00, LEVEL_ONE}) ? LEVEL_ONE : scaled[LEVEL_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      diff_ff <= diff_in;
      rms_ff <= rms_in;
      hi_ff <= hi_in;
      lo_ff <= lo_in;
   end

   assign done = done_ff;

endmodule

### hw/rtl/arlm_checker.sv
// port-level checks for the audio rms level meter, bound to the top level
// depends on arlm_pkg and on the top level's ports
`timescale 1ns / 1ps

module arlm_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_ready,
   input logic                         req_block_end,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic [arlm_pkg::LEVEL_W-1:0] rsp_smoothed_level,
   input logic [arlm_pkg::LEVEL_W-1:0] rsp_block_rms
);
   import arlm_pkg::*;

   logic prev_valid_ff;
   logic prev_ready_ff;
   logic pending_ff;
   logic new_word;

   // a fresh result word appears on the response side
   assign new_word = rsp_valid && (!prev_valid_ff || prev_ready_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_valid_ff <= 1'b0;
         prev_ready_ff <= 1'b0;
         pending_ff <= 1'b0;
      end else begin
         prev_valid_ff <= rsp_valid;
         prev_ready_ff <= rsp_ready;
         if (req_valid && req_ready && req_block_end) begin
            pending_ff <= 1'b1;
         end else if (new_word) begin
            pending_ff <= 1'b0;
         end
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response word dropped while stalled");

   a_level_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_smoothed_level <= LEVEL_ONE)
      else $error("smoothed level above full scale");

   a_rms_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_block_rms <= LEVEL_ONE)
      else $error("block rms above full scale");

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      new_word |-> pending_ff)
      else $error("response word without a closing frame word");

endmodule

bind audio_rms_level_meter arlm_checker u_arlm_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_bus.valid),
   .req_ready          (req_bus.ready),
   .req_block_end      (req_bus.block_end),
   .rsp_valid          (rsp_bus.valid),
   .rsp_ready          (rsp_bus.ready),
   .rsp_smoothed_level (rsp_bus.smoothed_level),
   .rsp_block_rms      (rsp_bus.block_rms)
);

### tb/arlm_level_checker.sv
// level meter checker: watches the frame, reading and csr ports and predicts every reading
// depends on arlm_pkg and the arlm_req_if / arlm_rsp_if interfaces
`timescale 1ns / 1ps

module arlm_level_checker #(
   parameter int MAX_FRAMES = 1024
) (
   input  logic                         clock,
   input  logic                         reset,
   arlm_req_if                          req_mon,
   arlm_rsp_if                          rsp_mon,
   input  logic                         csr_wr_en,
   input  logic [arlm_pkg::DECAY_W-1:0] csr_wr_data,
   output int                           fail_count,
   output int                           readings_due
);
   import arlm_pkg::*;

   localparam logic [63:0] SUM_CEILING = (64'd1 << SUM_W) - 64'd1;

   typedef struct packed {
      logic [LEVEL_W-1:0] level;
      logic [LEVEL_W-1:0] rms;
   } meter_reading_type;

   meter_reading_type  expected_readings[$];
   logic [SUM_W-1:0]   energy_sum;
   int unsigned        frames_in_block;
   logic [LEVEL_W-1:0] level_now;
   logic [DECAY_W-1:0] decay_now;

   // floor of the square root, two radicand bits per step
   function automatic logic [63:0] floor_sqrt(input logic [63:0] x);
      logic [63:0] root;
      logic [63:0] step_bit;
      logic [63:0] rem;
      root = '0;
      rem = x;
      step_bit = 64'd1 << 62;
      while (step_bit > rem)
         step_bit = step_bit >> 2;
      while (step_bit != 0) begin
         if (rem >= root + step_bit) begin
            rem = rem - (root + step_bit);
            root = (root >> 1) + step_bit;
         end else begin
            root = root >> 1;
         end
         step_bit = step_bit >> 2;
      end
      return root;
   endfunction

   // one accepted frame word; a block end queues the reading it produces
   task automatic accumulate_frame(input logic signed [15:0] left, input logic signed [15:0] right,
                                   input logic last);
      logic signed [16:0] pair_sum;
      logic signed [15:0] mid;
      logic [63:0]        square;
      logic [63:0]        total;
      logic [63:0]        mean;
      logic [63:0]        rms;
      logic [63:0]        blend;
      meter_reading_type  reading;
      pair_sum = 17'(left) + 17'(right);
      mid = 16'(pair_sum >>> 1);
      if (frames_in_block < MAX_FRAMES) begin
         square = 64'(longint'(mid) * longint'(mid));
         total = 64'(energy_sum) + square;
         if (total > SUM_CEILING)
            total = SUM_CEILING;
         energy_sum = total[SUM_W-1:0];
         frames_in_block++;
      end
      if (last) begin
         mean = 64'(energy_sum) / 64'(frames_in_block);
         rms = floor_sqrt(mean);
         if (rms > 64'(LEVEL_ONE))
            rms = 64'(LEVEL_ONE);
         blend = (64'(level_now) * 64'(decay_now) + rms * (64'd65536 - 64'(decay_now))
                  + 64'd32768) >> 16;
         if (blend > 64'(LEVEL_ONE))
            blend = 64'(LEVEL_ONE);
         level_now = blend[LEVEL_W-1:0];
         reading.level = level_now;
         reading.rms = rms[LEVEL_W-1:0];
         expected_readings = {expected_readings, reading};
         readings_due++;
         energy_sum = '0;
         frames_in_block = 0;
      end
   endtask

   always @(posedge clock) begin
      meter_reading_type want;
      if (reset) begin
         energy_sum = '0;
         frames_in_block = 0;
         level_now = '0;
         decay_now = DECAY_RESET;
         fail_count = 0;
         readings_due = 0;
         expected_readings.delete();
      end else begin
         if (csr_wr_en)
            decay_now = csr_wr_data;
         if (req_mon.valid && req_mon.ready)
            accumulate_frame(req_mon.left_sample, req_mon.right_sample, req_mon.block_end);
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_readings.size() == 0) begin
               $error("unexpected reading: smoothed_level %0d block_rms %0d",
                      rsp_mon.smoothed_level, rsp_mon.block_rms);
               fail_count++;
            end else begin
               want = expected_readings.pop_front();
               readings_due--;
               if (rsp_mon.smoothed_level !== want.level) begin
                  $error("smoothed_level: expected %0d, actual %0d",
                         want.level, rsp_mon.smoothed_level);
                  fail_count++;
               end
               if (rsp_mon.block_rms !== want.rms) begin
                  $error("block_rms: expected %0d, actual %0d", want.rms, rsp_mon.block_rms);
                  fail_count++;
               end
            end
         end
      end
   end

endmodule

### tb/audio_rms_level_meter_tb.sv
// top of the audio rms level meter testbench: clock, reset, frame stimulus and verdict
// depends on arlm_pkg, the channel interfaces, audio_rms_level_meter and arlm_level_checker
`timescale 1ns / 1ps

module audio_rms_level_meter_tb;
   import arlm_pkg::*;

   localparam int FULL_BLOCK    = 1024;
   localparam int RESET_CYCLES  = 11;
   // give the pipeline room after a block end before a csr write
   localparam int SETTLE_CYCLES = 150;
   localparam int CYCLE_LIMIT   = 1_000_000;

   logic               clock;
   logic               reset;
   logic               csr_wr_en;
   logic [DECAY_W-1:0] csr_wr_data;

   // idle and stall odds in percent, changed per phase
   int send_idle_pct;
   int recv_stall_pct;

   int fail_count;
   int readings_due;
   int cycle_count;

   arlm_req_if #(.SAMPLE_BITS(16)) req_bus ();
   arlm_rsp_if rsp_bus ();

   audio_rms_level_meter #(
      .MAX_FRAMES (FULL_BLOCK),
      .SAMPLE_BITS(16)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_bus    (req_bus),
      .rsp_bus    (rsp_bus),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   // predictor and scoreboard sit beside the block and only watch
   arlm_level_checker #(
      .MAX_FRAMES(FULL_BLOCK)
   ) level_check (
      .clock       (clock),
      .reset       (reset),
      .req_mon     (req_bus),
      .rsp_mon     (rsp_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .fail_count  (fail_count),
      .readings_due(readings_due)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // watchdog: a hung handshake ends the run here
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("audio_rms_level_meter_tb NOT OK");
      $finish;
   end

   // reading sink: ready toggles at the falling edge with the phase's stall odds
   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_bus.ready <= !($urandom_range(99) < recv_stall_pct);
      end
   end

   // sample picker: rails, near zero, quiet and full-range random values
   function automatic logic signed [15:0] pick_sample();
      logic signed [15:0] s;
      case ($urandom_range(9))
         0:       s = -16'sd32768;
         1:       s = 16'sd32767;
         2:       s = 16'sd0;
         3:       s = 16'($urandom_range(255)) - 16'sd128;
         4:       s = 16'($urandom_range(8191)) - 16'sd4096;
         default: s = 16'($urandom());
      endcase
      return s;
   endfunction

   // one frame word: optional idle gap, then hold valid until the block takes it;
   // returns at a falling edge with valid still high
   task automatic push_frame(input logic signed [15:0] left, input logic signed [15:0] right,
                             input logic last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.left_sample <= left;
      req_bus.right_sample <= right;
      req_bus.block_end <= last;
      @(posedge clock);
      while (!req_bus.ready)
         @(posedge clock);
      @(negedge clock);
   endtask

   // stop sending and let every pending reading come back, plus the pipeline tail
   task automatic drain_readings();
      req_bus.valid <= 1'b0;
      @(negedge clock);
      while (readings_due != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // decay weight write, only once the block has gone quiet
   task automatic write_decay(input logic [DECAY_W-1:0] weight);
      drain_readings();
      csr_wr_en <= 1'b1;
      csr_wr_data <= weight;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // random blocks, mostly short; the last one may be cut off and carry into the next phase
   task automatic run_blocks(input int frame_total);
      int sent;
      int len;
      int k;
      logic signed [15:0] left;
      logic signed [15:0] right;
      sent = 0;
      while (sent < frame_total) begin
         len = ($urandom_range(9) == 0) ? $urandom_range(13, 80) : $urandom_range(1, 12);
         for (k = 0; k < len && sent < frame_total; k++) begin
            left = pick_sample();
            // correlated channels push the mid value toward its extremes or toward zero
            case ($urandom_range(5))
               0:       right = left;
               1:       right = -left;
               default: right = pick_sample();
            endcase
            push_frame(left, right, k == len - 1);
            sent++;
         end
      end
   endtask

   // block longer than the frame limit: the loud tail must be dropped, the end word still closes it
   task automatic run_overfull_block(input int extra);
      int k;
      logic signed [15:0] quiet;
      for (k = 0; k < FULL_BLOCK + extra; k++) begin
         if (k < FULL_BLOCK) begin
            quiet = 16'($urandom_range(4095)) - 16'sd2048;
            push_frame(quiet, 16'($urandom_range(4095)) - 16'sd2048, 1'b0);
         end else if (k[0]) begin
            push_frame(16'sd32767, 16'sd32767, k == FULL_BLOCK + extra - 1);
         end else begin
            push_frame(-16'sd32768, -16'sd32768, k == FULL_BLOCK + extra - 1);
         end
      end
   endtask

   initial begin
      reset = 1'b1;
      csr_wr_en = 1'b0;
      csr_wr_data = '0;
      req_bus.valid = 1'b0;
      req_bus.left_sample = '0;
      req_bus.right_sample = '0;
      req_bus.block_end = 1'b0;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      repeat (RESET_CYCLES) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed words at the reset decay weight
      push_frame(-16'sd32768, -16'sd32768, 1'b1);   // most negative mid, rms hits 1.0
      push_frame(16'sd32767, 16'sd32767, 1'b1);     // most positive mid
      push_frame(16'sd32767, -16'sd32768, 1'b1);    // odd sum rounds down to -1
      push_frame(-16'sd1, 16'sd0, 1'b0);            // floor of negative half
      push_frame(16'sd1, 16'sd0, 1'b0);
      push_frame(16'sd0, -16'sd1, 1'b1);
      push_frame(16'sd0, 16'sd0, 1'b1);             // silent block, level decays
      push_frame(-16'sd32768, 16'sd32767, 1'b0);
      push_frame(16'sd16384, 16'sd16384, 1'b0);
      push_frame(-16'sd16384, -16'sd16384, 1'b0);
      push_frame(16'sd100, -16'sd300, 1'b1);
      push_frame(16'sd12345, -16'sd6789, 1'b1);
      push_frame(16'sd21845, -16'sd21846, 1'b0);    // alternating bit patterns
      push_frame(-16'sd21846, 16'sd21845, 1'b1);
      push_frame(16'sd0, 16'sd0, 1'b1);

      // no smoothing: level follows the block rms
      write_decay(16'd0);
      run_blocks(180);

      // heaviest smoothing, sender mostly idle
      write_decay(16'hFFFF);
      send_idle_pct = 82;
      run_blocks(180);

      // random weight, reading sink mostly stalled
      write_decay(16'($urandom_range(65535)));
      send_idle_pct = 0;
      recv_stall_pct = 82;
      run_blocks(180);

      // default weight written back, light idling on both sides, frame limit overrun
      write_decay(DECAY_RESET);
      send_idle_pct = 24;
      recv_stall_pct = 24;
      run_overfull_block(5);
      run_blocks(60);

      write_decay(16'($urandom_range(65535)));
      send_idle_pct = 82;
      recv_stall_pct = 0;
      run_blocks(180);

      write_decay(16'd1);
      send_idle_pct = 24;
      recv_stall_pct = 24;
      run_blocks(120);

      drain_readings();
      if (fail_count == 0 && readings_due == 0) begin
         $display("audio_rms_level_meter_tb OK");
      end else begin
         $display("audio_rms_level_meter_tb NOT OK");
      end
      $finish;
   end

endmodule
